@@ design/cstr_pkg.sv @@
// types and constants shared by the count-smaller-to-right block
package cstr_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] smaller_count;
    logic               final_result;
    logic               truncated;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_PIVOT = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

@@ design/count_smaller_to_right.sv @@
// top level: counts, for each stored element, the later elements smaller than it
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready   | in_data   (cstr_pkg::in_item_t)
//   out_    | output    | out_valid/out_ready | out_data  (cstr_pkg::out_item_t)
//
// a transaction that does not end a set leaves the block idle and ready for the next one
// after the set-ending transaction, for each of the n stored elements in turn,
//   the single comparator walks the later elements in memory one read per cycle
// rst_n is synchronous; the element memory holds no reset and needs no clearing pass
// the block takes no input while a set is being worked on or a result waits for out_ready
module count_smaller_to_right #(
  parameter int MAX_LEN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cstr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cstr_pkg::out_item_t out_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  logic signed [cstr_pkg::SAMPLE_W-1:0] mem [MAX_LEN];
  logic signed [cstr_pkg::SAMPLE_W-1:0] rd_data_r;
  logic signed [cstr_pkg::SAMPLE_W-1:0] pivot_r, pivot_nxt;
  logic [AW-1:0]                        rd_addr;

  cstr_pkg::state_t state_r, state_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [LW-1:0] i_r, i_nxt;
  logic [LW-1:0] j_r, j_nxt;
  logic          pend_r, pend_nxt;
  logic [cstr_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  cstr_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_acc;
  logic room;
  logic last_pos;

  assign in_ready  = (state_r == cstr_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign room      = (fill_r < LW'(MAX_LEN));
  assign last_pos  = (i_r == fill_r - LW'(1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (state_r == cstr_pkg::ST_SCAN) begin
      rd_addr = j_r[AW-1:0];
    end else begin
      rd_addr = i_r[AW-1:0];
    end
  end

  // element memory
  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[fill_r[AW-1:0]] <= in_data.sample;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    pivot_nxt     = pivot_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      cstr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (room) begin
            fill_nxt = fill_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.end_of_set) begin
            i_nxt     = '0;
            state_nxt = cstr_pkg::ST_FETCH;
          end
        end
      end
      cstr_pkg::ST_FETCH: begin
        state_nxt = cstr_pkg::ST_PIVOT;
      end
      cstr_pkg::ST_PIVOT: begin
        pivot_nxt = rd_data_r;
        j_nxt     = i_r + LW'(1);
        pend_nxt  = 1'b0;
        cnt_nxt   = '0;
        state_nxt = cstr_pkg::ST_SCAN;
      end
      cstr_pkg::ST_SCAN: begin
        // shared comparator on the previous read
        if (pend_r && (rd_data_r < pivot_r)) begin
          cnt_nxt = cnt_r + cstr_pkg::COUNT_W'(1);
        end
        if (j_r < fill_r) begin
          j_nxt    = j_r + LW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.smaller_count = cnt_r;
            out_data_nxt.final_result  = last_pos;
            out_data_nxt.truncated     = ovf_r;
            state_nxt                  = cstr_pkg::ST_EMIT;
          end
        end
      end
      cstr_pkg::ST_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_pos) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = cstr_pkg::ST_IDLE;
          end else begin
            i_nxt     = i_r + LW'(1);
            state_nxt = cstr_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = cstr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cstr_pkg::ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    pivot_r    <= pivot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
